@@ src/cdmg_pkg.sv @@
// ----------------------------------------------------------------------------
// cdmg_pkg: shared types and constants
// Widths, register indexes and beat structs for the cubic distortion map
// generator.
// ----------------------------------------------------------------------------
package cdmg_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 8;

  localparam int CFG_W   = 64;
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 12;
  localparam int COORD_W = PIX_W + 2;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int CUBE_W  = 3 * COORD_W;
  localparam int COEF_W  = 32;
  localparam int LO_SHIFT = COEF_W / 2;
  localparam int OUT_W   = 24;

  localparam int HI_PROD_W = LO_SHIFT + CUBE_W;
  localparam int LO_PROD_W = LO_SHIFT + 1 + CUBE_W;
  localparam int SQ_PROD_W = COEF_W + SQ_W;
  localparam int SUM_W     = 64;
  localparam int ACC_W     = SUM_W + LO_SHIFT;
  localparam int RND_SHIFT = 48 - FRAC_BITS;
  localparam int RND_W     = ACC_W - RND_SHIFT;

  localparam int MID_DEPTH = 5;
  localparam int OUT_DEPTH = 8;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_CUBE_X  = 3'd2,
    REG_COEF_CUBE_Y  = 3'd3,
    REG_COEF_X_YSQ   = 3'd4,
    REG_COEF_XSQ_Y   = 3'd5,
    REG_COEF_SQ_X    = 3'd6,
    REG_COEF_SQ_Y    = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_row;
    logic [PIX_W-1:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cube_x;
    logic signed [COEF_W-1:0] cube_y;
    logic signed [COEF_W-1:0] x_ysq;
    logic signed [COEF_W-1:0] xsq_y;
    logic signed [COEF_W-1:0] square_x;
    logic signed [COEF_W-1:0] square_y;
  } coef_set_t;

  typedef struct packed {
    logic signed [CUBE_W-1:0] cube_x;
    logic signed [CUBE_W-1:0] cube_y;
    logic signed [CUBE_W-1:0] x_ysq;
    logic signed [CUBE_W-1:0] xsq_y;
    logic signed [SQ_W-1:0]   square_x;
    logic signed [SQ_W-1:0]   square_y;
  } mono_t;

  typedef struct packed {
    mono_t            mono;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } mid_item_t;

endpackage

@@ src/cdmg_fifo.sv @@
// ----------------------------------------------------------------------------
// cdmg_fifo: small register queue
// Circular buffer with fall-through read; the writer is credit controlled,
// so no full flag is produced.
// ----------------------------------------------------------------------------
module cdmg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cdmg_pkg::MID_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

@@ src/cdmg_front.sv @@
// ----------------------------------------------------------------------------
// cdmg_front: centring and monomial stages
// Three stages: centre on the midpoint, square, then the cubic and mixed
// terms.
// ----------------------------------------------------------------------------
module cdmg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  cdmg_pkg::pixel_t             pixel,
  input  logic [cdmg_pkg::PIX_W-1:0]   half_width,
  input  logic [cdmg_pkg::PIX_W-1:0]   half_height,
  output logic                         out_valid,
  output cdmg_pkg::mid_item_t          out_item
);

  logic                                valid1;
  logic                                valid2;
  logic signed [cdmg_pkg::COORD_W-1:0] x1;
  logic signed [cdmg_pkg::COORD_W-1:0] y1;
  logic [cdmg_pkg::PIX_W-1:0]          row1;
  logic [cdmg_pkg::PIX_W-1:0]          col1;
  logic signed [cdmg_pkg::COORD_W-1:0] x2;
  logic signed [cdmg_pkg::COORD_W-1:0] y2;
  logic signed [cdmg_pkg::SQ_W-1:0]    xx2;
  logic signed [cdmg_pkg::SQ_W-1:0]    yy2;
  logic [cdmg_pkg::PIX_W-1:0]          row2;
  logic [cdmg_pkg::PIX_W-1:0]          col2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    x1   <= cdmg_pkg::COORD_W'(pixel.pixel_col) - cdmg_pkg::COORD_W'(half_width);
    y1   <= cdmg_pkg::COORD_W'(pixel.pixel_row) - cdmg_pkg::COORD_W'(half_height);
    row1 <= pixel.pixel_row;
    col1 <= pixel.pixel_col;

    xx2  <= x1 * x1;
    yy2  <= y1 * y1;
    x2   <= x1;
    y2   <= y1;
    row2 <= row1;
    col2 <= col1;

    out_item.mono.cube_x   <= xx2 * x2;
    out_item.mono.cube_y   <= yy2 * y2;
    out_item.mono.x_ysq    <= yy2 * x2;
    out_item.mono.xsq_y    <= xx2 * y2;
    out_item.mono.square_x <= xx2;
    out_item.mono.square_y <= yy2;
    out_item.row           <= row2;
    out_item.col           <= col2;
  end

endmodule

@@ src/cdmg_back.sv @@
// ----------------------------------------------------------------------------
// cdmg_back: coefficient products, rounding and saturation
// Six stages for both axes: products, pair sums, final sums, merge of the
// split cubic terms, round half up, add base pixel and clip.
// ----------------------------------------------------------------------------
module cdmg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  cdmg_pkg::mid_item_t  in_item,
  input  cdmg_pkg::coef_set_t  coef_x,
  input  cdmg_pkg::coef_set_t  coef_y,
  output logic                 out_valid,
  output cdmg_pkg::result_t    out_item
);

  localparam int ACC_W = cdmg_pkg::ACC_W;
  localparam int SUM_W = cdmg_pkg::SUM_W;
  localparam int RND_W = cdmg_pkg::RND_W;
  localparam int VW    = RND_W + 1;
  localparam int PW    = cdmg_pkg::PIX_W;
  localparam int LS    = cdmg_pkg::LO_SHIFT;
  localparam int CW    = cdmg_pkg::COEF_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (cdmg_pkg::RND_SHIFT - 1);
  localparam logic signed [VW-1:0] OUT_MAX = VW'((1 << (cdmg_pkg::OUT_W - 1)) - 1);
  localparam logic signed [VW-1:0] OUT_MIN = -VW'(1 << (cdmg_pkg::OUT_W - 1));

  logic [5:0] valid;

  logic signed [CW-1:0]                  coef  [2][6];
  logic signed [cdmg_pkg::CUBE_W-1:0]    cube  [4];
  logic signed [cdmg_pkg::SQ_W-1:0]      sq    [2];
  logic [PW-1:0]                         base  [2];

  logic signed [cdmg_pkg::HI_PROD_W-1:0] prod_hi [2][4];
  logic signed [cdmg_pkg::LO_PROD_W-1:0] prod_lo [2][4];
  logic signed [cdmg_pkg::SQ_PROD_W-1:0] prod_sq [2][2];
  logic signed [SUM_W-1:0]               hs0 [2];
  logic signed [SUM_W-1:0]               hs1 [2];
  logic signed [SUM_W-1:0]               qs  [2];
  logic signed [SUM_W-1:0]               ls0 [2];
  logic signed [SUM_W-1:0]               ls1 [2];
  logic signed [SUM_W-1:0]               hq  [2];
  logic signed [SUM_W-1:0]               ls  [2];
  logic signed [ACC_W-1:0]               tsum [2];
  logic signed [ACC_W-1:0]               rsum [2];
  logic signed [RND_W-1:0]               rnd  [2];
  logic signed [VW-1:0]                  total [2];
  logic                                  clip [2];
  logic signed [cdmg_pkg::OUT_W-1:0]     clipped [2];

  logic [PW-1:0] base_p [2];
  logic [PW-1:0] base_a [2];
  logic [PW-1:0] base_b [2];
  logic [PW-1:0] base_c [2];
  logic [PW-1:0] base_d [2];

  always_comb begin
    coef[0][0] = coef_x.cube_x;
    coef[0][1] = coef_x.cube_y;
    coef[0][2] = coef_x.x_ysq;
    coef[0][3] = coef_x.xsq_y;
    coef[0][4] = coef_x.square_x;
    coef[0][5] = coef_x.square_y;
    coef[1][0] = coef_y.cube_x;
    coef[1][1] = coef_y.cube_y;
    coef[1][2] = coef_y.x_ysq;
    coef[1][3] = coef_y.xsq_y;
    coef[1][4] = coef_y.square_x;
    coef[1][5] = coef_y.square_y;
    cube[0]    = in_item.mono.cube_x;
    cube[1]    = in_item.mono.cube_y;
    cube[2]    = in_item.mono.x_ysq;
    cube[3]    = in_item.mono.xsq_y;
    sq[0]      = in_item.mono.square_x;
    sq[1]      = in_item.mono.square_y;
    base[0]    = in_item.col;
    base[1]    = in_item.row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[4:0], in_valid};
    end
  end

  // cubic coefficients split into a signed high half and an unsigned low half
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        prod_hi[a][k] <= $signed(coef[a][k][CW-1:LS]) * cube[k];
        prod_lo[a][k] <= $signed({1'b0, coef[a][k][LS-1:0]}) * cube[k];
      end
      prod_sq[a][0] <= coef[a][4] * sq[0];
      prod_sq[a][1] <= coef[a][5] * sq[1];
      base_p[a]     <= base[a];

      hs0[a]    <= SUM_W'(prod_hi[a][0]) + SUM_W'(prod_hi[a][1]);
      hs1[a]    <= SUM_W'(prod_hi[a][2]) + SUM_W'(prod_hi[a][3]);
      qs[a]     <= SUM_W'(prod_sq[a][0]) + SUM_W'(prod_sq[a][1]);
      ls0[a]    <= SUM_W'(prod_lo[a][0]) + SUM_W'(prod_lo[a][1]);
      ls1[a]    <= SUM_W'(prod_lo[a][2]) + SUM_W'(prod_lo[a][3]);
      base_a[a] <= base_p[a];

      hq[a]     <= hs0[a] + hs1[a] + qs[a];
      ls[a]     <= ls0[a] + ls1[a];
      base_b[a] <= base_a[a];

      tsum[a]   <= $signed({hq[a], LS'(0)}) + ACC_W'(ls[a]);
      base_c[a] <= base_b[a];

      rnd[a]    <= rsum[a][ACC_W-1:cdmg_pkg::RND_SHIFT];
      base_d[a] <= base_c[a];
    end
    out_item.source_x  <= clipped[0];
    out_item.source_y  <= clipped[1];
    out_item.saturated <= clip[0] | clip[1];
  end

  // negated polynomial, round half up, then base pixel and clip
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rsum[a]  = RND_HALF - tsum[a];
      total[a] = VW'(rnd[a]) + (VW'($signed({1'b0, base_d[a]})) <<< cdmg_pkg::FRAC_BITS);
      if (total[a] > OUT_MAX) begin
        clip[a]    = 1'b1;
        clipped[a] = OUT_MAX[cdmg_pkg::OUT_W-1:0];
      end else if (total[a] < OUT_MIN) begin
        clip[a]    = 1'b1;
        clipped[a] = OUT_MIN[cdmg_pkg::OUT_W-1:0];
      end else begin
        clip[a]    = 1'b0;
        clipped[a] = total[a][cdmg_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_valid = valid[5];

endmodule

@@ src/cubic_distortion_map_generator_core.sv @@
// Path: an accepted beat passes the 3 front stages, the mid queue, the 6 back
// stages and the output queue to reach the output queue head; it waits in the
// mid queue while the output queue credits are spent.
// Throughput: one beat per cycle while full is low; credits cover the 5-entry
// mid queue and the 8-entry output queue.
// Reset: synchronous; 1024 x 1024, zero coefficients, queues empty, ready at once.
// ----------------------------------------------------------------------------
// cubic_distortion_map_generator_core: lens distortion remap coordinates
// Maps each output pixel position to a saturated Q15.8 source coordinate
// through a cubic polynomial per axis.
// ----------------------------------------------------------------------------
module cubic_distortion_map_generator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  cdmg_pkg::pixel_t             pixel,
  output logic                         empty,
  input  logic                         pop,
  output cdmg_pkg::result_t            result,
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [cdmg_pkg::CFG_W-1:0]   cfg_data
);

  localparam int MID_CNT_W = $clog2(cdmg_pkg::MID_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(cdmg_pkg::OUT_DEPTH + 1);
  localparam int DIM_W     = cdmg_pkg::DIM_W;
  localparam int CW        = cdmg_pkg::COEF_W;

  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  cdmg_pkg::coef_set_t  coef_x;
  cdmg_pkg::coef_set_t  coef_y;
  logic [DIM_W-1:0]     dim_clamped;

  logic                 accept;
  logic                 out_pop;
  logic                 mid_pop;
  logic                 mid_empty;
  logic [MID_CNT_W-1:0] front_cnt;
  logic [MID_CNT_W-1:0] front_cnt_next;
  logic [OUT_CNT_W-1:0] back_cnt;
  logic [OUT_CNT_W-1:0] back_cnt_next;

  logic                 front_valid;
  cdmg_pkg::mid_item_t  front_item;
  cdmg_pkg::mid_item_t  mid_item;
  logic                 back_valid;
  cdmg_pkg::result_t    back_item;

  assign dim_clamped = (cfg_data[DIM_W-1:0] > DIM_W'(cdmg_pkg::MAX_DIM)) ?
                       DIM_W'(cdmg_pkg::MAX_DIM) : cfg_data[DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1024);
      image_height <= DIM_W'(1024);
      coef_x       <= '0;
      coef_y       <= '0;
    end else if (cfg_write) begin
      case (cdmg_pkg::reg_index_t'(cfg_index))
        cdmg_pkg::REG_IMAGE_WIDTH: begin
          image_width <= dim_clamped;
        end
        cdmg_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= dim_clamped;
        end
        cdmg_pkg::REG_COEF_CUBE_X: begin
          coef_x.cube_x <= cfg_data[CW-1:0];
          coef_y.cube_x <= cfg_data[2*CW-1:CW];
        end
        cdmg_pkg::REG_COEF_CUBE_Y: begin
          coef_x.cube_y <= cfg_data[CW-1:0];
          coef_y.cube_y <= cfg_data[2*CW-1:CW];
        end
        cdmg_pkg::REG_COEF_X_YSQ: begin
          coef_x.x_ysq <= cfg_data[CW-1:0];
          coef_y.x_ysq <= cfg_data[2*CW-1:CW];
        end
        cdmg_pkg::REG_COEF_XSQ_Y: begin
          coef_x.xsq_y <= cfg_data[CW-1:0];
          coef_y.xsq_y <= cfg_data[2*CW-1:CW];
        end
        cdmg_pkg::REG_COEF_SQ_X: begin
          coef_x.square_x <= cfg_data[CW-1:0];
          coef_y.square_x <= cfg_data[2*CW-1:CW];
        end
        cdmg_pkg::REG_COEF_SQ_Y: begin
          coef_x.square_y <= cfg_data[CW-1:0];
          coef_y.square_y <= cfg_data[2*CW-1:CW];
        end
        default: begin
        end
      endcase
    end
  end

  // credits: front stages plus mid queue, back stages plus output queue
  assign full    = (front_cnt == MID_CNT_W'(cdmg_pkg::MID_DEPTH));
  assign accept  = push & ~full;
  assign out_pop = pop & ~empty;
  assign mid_pop = ~mid_empty & (back_cnt != OUT_CNT_W'(cdmg_pkg::OUT_DEPTH));

  assign front_cnt_next = front_cnt + MID_CNT_W'(accept) - MID_CNT_W'(mid_pop);
  assign back_cnt_next  = back_cnt + OUT_CNT_W'(mid_pop) - OUT_CNT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cnt <= '0;
      back_cnt  <= '0;
    end else begin
      front_cnt <= front_cnt_next;
      back_cnt  <= back_cnt_next;
    end
  end

  cdmg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .pixel       (pixel),
    .half_width  (image_width[DIM_W-1:1]),
    .half_height (image_height[DIM_W-1:1]),
    .out_valid   (front_valid),
    .out_item    (front_item)
  );

  cdmg_fifo #(
    .WIDTH ($bits(cdmg_pkg::mid_item_t)),
    .DEPTH (cdmg_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_item),
    .rd_en   (mid_pop),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  cdmg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_pop),
    .in_item   (mid_item),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .out_valid (back_valid),
    .out_item  (back_item)
  );

  cdmg_fifo #(
    .WIDTH ($bits(cdmg_pkg::result_t)),
    .DEPTH (cdmg_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_valid),
    .wr_data (back_item),
    .rd_en   (out_pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
